// File: hw/rtl/tmsf_pkg.sv
// tmsf_pkg: shared types and constants for the timed message stream filter
// no dependencies; imported by every module of the filter

package tmsf_pkg;

  // header geometry: three little-endian 32-bit words
  localparam int unsigned HDR_BYTES = 12;
  localparam logic [3:0]  HDR_LAST  = 4'd11;

  // configuration register indexes
  localparam logic [1:0] CFG_TYPE_LIMIT = 2'd0;
  localparam logic [1:0] CFG_TIME_SLACK = 2'd1;

  // register reset values
  localparam logic [31:0] TYPE_LIMIT_RST = 32'd4;
  localparam logic [7:0]  TIME_SLACK_RST = 8'd2;

  // one queue entry: either a whole kept header or a single payload byte
  typedef struct packed {
    logic        is_header;
    logic        last;
    logic [95:0] data;
  } tmsf_entry_t;

  // queue occupancy flags seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } tmsf_qstat_t;

endpackage

// File: hw/rtl/tmsf_front.sv
// tmsf_front: byte parser, keep decision and configuration registers
// depends on tmsf_pkg; pushes work into tmsf_queue

module tmsf_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_byte,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  input  tmsf_pkg::tmsf_qstat_t qstat,
  output logic                 push,
  output tmsf_pkg::tmsf_entry_t push_entry
);
  import tmsf_pkg::*;

  logic        in_payload;
  logic [3:0]  header_index;
  logic [87:0] hdr;
  logic [31:0] payload_left;
  logic        keep_current;
  logic [31:0] max_time_seen;
  logic [31:0] type_limit;
  logic [7:0]  time_slack;

  logic        accept;
  logic        last_hdr;
  logic [95:0] full_hdr;
  logic [31:0] msg_type;
  logic [31:0] msg_time;
  logic [31:0] msg_len;
  logic [31:0] slack_sum;
  logic        type_ok;
  logic        newer;
  logic        keep;

  assign in_stall = qstat.full;
  assign accept   = in_valid && !qstat.full;
  assign last_hdr = !in_payload && (header_index == HDR_LAST);

  // complete header as it stands with the current byte on top
  assign full_hdr  = {in_byte, hdr};
  assign msg_type  = full_hdr[31:0];
  assign msg_time  = full_hdr[63:32];
  assign msg_len   = full_hdr[95:64];
  assign slack_sum = msg_time + {24'd0, time_slack};
  assign type_ok   = (msg_type != 32'd0) && (msg_type <= type_limit);
  assign newer     = msg_time > max_time_seen;
  assign keep      = type_ok && (newer || (slack_sum > max_time_seen));

  always_comb begin
    push_entry = '0;
    if (in_payload) begin
      push                 = accept && keep_current;
      push_entry.is_header = 1'b0;
      push_entry.last      = (payload_left == 32'd1);
      push_entry.data      = {88'd0, in_byte};
    end else begin
      push                 = accept && last_hdr && keep;
      push_entry.is_header = 1'b1;
      push_entry.last      = (msg_len == 32'd0);
      push_entry.data      = full_hdr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      type_limit <= TYPE_LIMIT_RST;
      time_slack <= TIME_SLACK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TYPE_LIMIT: type_limit <= cfg_data;
        CFG_TIME_SLACK: time_slack <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_payload    <= 1'b0;
      header_index  <= '0;
      payload_left  <= '0;
      keep_current  <= 1'b0;
      max_time_seen <= '0;
    end else if (accept) begin
      if (in_payload) begin
        payload_left <= payload_left - 32'd1;
        if (payload_left == 32'd1) begin
          in_payload   <= 1'b0;
          keep_current <= 1'b0;
        end
      end else if (last_hdr) begin
        header_index <= '0;
        payload_left <= msg_len;
        in_payload   <= (msg_len != 32'd0);
        keep_current <= keep && (msg_len != 32'd0);
        if (type_ok && newer) begin
          max_time_seen <= msg_time;
        end
      end else begin
        header_index <= header_index + 4'd1;
      end
    end
  end

  // header byte capture, no reset needed
  always_ff @(posedge clk) begin
    if (accept && !in_payload && !last_hdr) begin
      for (int j = 0; j < HDR_BYTES - 1; j++) begin
        if (header_index == j[3:0]) begin
          hdr[j*8 +: 8] <= in_byte;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_hdr_index_range: assert property (@(posedge clk) disable iff (rst)
    header_index <= HDR_LAST)
    else $error("header index past last header byte");

  a_payload_nonzero: assert property (@(posedge clk) disable iff (rst)
    in_payload |-> (payload_left != 32'd0) && (header_index == 4'd0))
    else $error("payload phase with nothing left or header half collected");
`endif

endmodule

// File: hw/rtl/tmsf_queue.sv
// tmsf_queue: small first-word-fall-through queue between front and back
// depends on tmsf_pkg for the entry and status types

module tmsf_queue #(
  parameter int DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  tmsf_pkg::tmsf_entry_t push_entry,
  input  logic                  pop,
  output tmsf_pkg::tmsf_entry_t head,
  output tmsf_pkg::tmsf_qstat_t qstat
);
  import tmsf_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  tmsf_entry_t       slots [DEPTH];
  logic [AW-1:0]     wr_ptr;
  logic [AW-1:0]     rd_ptr;
  logic [CW-1:0]     count;

  assign head        = slots[rd_ptr];
  assign qstat.full  = (count == CNT_FULL);
  assign qstat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    !(push && qstat.full) && !(pop && qstat.empty))
    else $error("queue pushed when full or popped when empty");
`endif

endmodule

// File: hw/rtl/tmsf_back.sv
// tmsf_back: output stage, serialises kept headers and passes payload bytes
// depends on tmsf_pkg; pops entries from tmsf_queue

module tmsf_back (
  input  logic                  clk,
  input  logic                  rst,
  input  tmsf_pkg::tmsf_entry_t head,
  input  tmsf_pkg::tmsf_qstat_t qstat,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_byte,
  output logic                  msg_last
);
  import tmsf_pkg::*;

  tmsf_entry_t cur;
  logic        cur_valid;
  logic [3:0]  cnt;
  logic        take;
  logic        done;
  logic        load;

  assign out_valid = cur_valid;
  assign out_byte  = cur.is_header ? cur.data[{cnt, 3'b000} +: 8] : cur.data[7:0];
  assign msg_last  = cur.is_header ? (cur.last && (cnt == HDR_LAST)) : cur.last;

  assign take = cur_valid && !out_stall;
  assign done = !cur.is_header || (cnt == HDR_LAST);
  assign load = !cur_valid || (take && done);
  assign pop  = load && !qstat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      cnt       <= '0;
    end else if (take && !done) begin
      cnt <= cnt + 4'd1;
    end else if (load) begin
      cur_valid <= !qstat.empty;
      cnt       <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

`ifndef SYNTHESIS
  a_byte_count: assert property (@(posedge clk) disable iff (rst)
    (cnt <= HDR_LAST) && ((cur_valid && !cur.is_header) ? (cnt == 4'd0) : 1'b1))
    else $error("header byte count out of range or set on a payload byte");
`endif

endmodule

// File: hw/rtl/timed_message_stream_filter.sv
// timed_message_stream_filter: top level of the message filter
// depends on tmsf_pkg, tmsf_front, tmsf_queue and tmsf_back

// Filters a byte stream of messages, each a 12-byte header (type, time and
// payload length as little-endian 32-bit words) followed by its payload.
// A message is kept when its type lies from one to type_limit and its time
// is newer than the running maximum (which then moves up) or within
// time_slack of it. A kept message comes out as its 12 header bytes, then
// its payload bytes; msg_last marks its final byte. The input takes one byte
// per cycle. A kept header leaves as 12 output transactions from one queue
// entry, serialised by the output stage, so the output sets the pace: the
// input stalls only while the DEPTH-entry queue between the parser and the
// output stage is full. A kept header is pushed on its twelfth byte and its
// payload bytes queue up behind it while the header is serialised, so up to
// twelve entries wait; the default depth of 13 keeps the input at one byte
// per cycle unless the output stalls. A kept header or payload byte passes
// through a queue slot and then the output stage register. Configuration
// writes (index 0 type_limit, index 1 time_slack) take effect on the next
// cycle; other indexes are ignored.

module timed_message_stream_filter #(
  parameter int DEPTH = 13
) (
  input  logic        clk,
  input  logic        rst,
  // input byte stream
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  // kept message stream
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        msg_last,
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import tmsf_pkg::*;

  // front to queue
  logic        push;
  tmsf_entry_t push_entry;
  // queue to back
  logic        pop;
  tmsf_entry_t head;
  tmsf_qstat_t qstat;

  // parser and keep decision
  tmsf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .qstat      (qstat),
    .push       (push),
    .push_entry (push_entry)
  );

  // decouples parsing from output back-pressure
  tmsf_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .qstat      (qstat)
  );

  // header serialiser and output register
  tmsf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .qstat     (qstat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .msg_last  (msg_last)
  );

endmodule

// File: verif/tmsf_checker.sv
// tmsf_checker: watches the byte, kept-message and configuration ports of the filter,
// predicts every kept byte and compares it with what comes out; depends on tmsf_pkg
`timescale 1ns / 1ps

module tmsf_checker
  import tmsf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_byte,
  input  logic        msg_last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          mismatches,
  output int          pending
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_beat_t;

  out_beat_t   kept_bytes_due[$];
  out_beat_t   due_beat;

  logic [31:0] type_limit;
  logic [7:0]  time_slack;
  logic        in_body;
  logic [3:0]  hdr_pos;
  logic [95:0] hdr;
  logic [31:0] body_left;
  logic        keep_msg;
  logic [31:0] newest_time;

  // header words sit little-endian in hdr: type [31:0], time [63:32], length [95:64]
  task automatic filter_byte(input logic [7:0] b);
    logic [31:0] msg_type;
    logic [31:0] msg_time;
    logic [31:0] reach;
    int          k;
    if (in_body) begin
      if (keep_msg) kept_bytes_due.push_back('{data: b, last: body_left == 32'd1});
      body_left--;
      if (body_left == 32'd0) begin
        in_body  = 1'b0;
        keep_msg = 1'b0;
      end
    end else begin
      hdr[{hdr_pos, 3'b000} +: 8] = b;
      if (hdr_pos != HDR_LAST) begin
        hdr_pos++;
      end else begin
        hdr_pos   = '0;
        msg_type  = hdr[31:0];
        msg_time  = hdr[63:32];
        body_left = hdr[95:64];
        reach     = msg_time + {24'd0, time_slack};
        // bad type rejects before any time comparison
        if (msg_type == 32'd0 || msg_type > type_limit) begin
          keep_msg = 1'b0;
        end else if (msg_time > newest_time) begin
          newest_time = msg_time;
          keep_msg    = 1'b1;
        end else begin
          keep_msg = reach > newest_time;
        end
        in_body = body_left != 32'd0;
        if (keep_msg) begin
          for (k = 0; k < HDR_BYTES; k++)
            kept_bytes_due.push_back('{data: hdr[k*8 +: 8],
                                       last: (k == HDR_BYTES - 1) && !in_body});
        end
        if (!in_body) keep_msg = 1'b0;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      type_limit  = TYPE_LIMIT_RST;
      time_slack  = TIME_SLACK_RST;
      in_body     = 1'b0;
      hdr_pos     = '0;
      hdr         = '0;
      body_left   = '0;
      keep_msg    = 1'b0;
      newest_time = '0;
      mismatches  = 0;
      kept_bytes_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (kept_bytes_due.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected output byte %02h last %0b", $realtime, out_byte,
                     msg_last);
          mismatches++;
        end else begin
          due_beat = kept_bytes_due.pop_front();
          if (due_beat.data !== out_byte || due_beat.last !== msg_last) begin
            if (mismatches < 10)
              $display("%0t: output mismatch: expected byte %02h last %0b, got %02h last %0b",
                       $realtime, due_beat.data, due_beat.last, out_byte, msg_last);
            mismatches++;
          end
        end
      end
      // a byte taken on the same edge as a register write still sees the old value
      if (in_valid && !in_stall) filter_byte(in_byte);
      if (cfg_we) begin
        case (cfg_index)
          CFG_TYPE_LIMIT: type_limit = cfg_data;
          CFG_TIME_SLACK: time_slack = cfg_data[7:0];
          default: ;
        endcase
      end
    end
    pending = kept_bytes_due.size();
  end

endmodule

// File: verif/timed_message_stream_filter_test.sv
// timed_message_stream_filter_test: stimulus and verdict for the message filter
// depends on tmsf_pkg, timed_message_stream_filter and tmsf_checker
`timescale 1ns / 1ps

module timed_message_stream_filter_test;
  import tmsf_pkg::*;

  // register indexes past the end of the list; writes to them must be ignored
  localparam logic [1:0] CFG_SPARE_A = 2'd2;
  localparam logic [1:0] CFG_SPARE_B = 2'd3;

  // cycles to let the pipeline settle before a register write
  localparam int HOLD_OFF    = 6;
  // cycles with no transaction on either channel before the run is abandoned
  localparam int QUIET_LIMIT = 2000;
  // input byte budget of most random phases
  localparam int PHASE_BYTES = 25;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_byte;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        msg_last;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  int          mismatches;
  int          pending;

  // pacing of both sides, in percent of cycles
  int          idle_pct;
  int          stall_pct;

  // what the stimulus knows of the configuration and of the newest kept time
  logic [31:0] type_cap;
  logic [7:0]  slack_now;
  logic [31:0] time_now;

  int          bytes_fed;
  int          bytes_out;
  int          msgs_out;
  int          quiet;

  timed_message_stream_filter DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .msg_last  (msg_last),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tmsf_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .msg_last   (msg_last),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always #2 clk = ~clk;

  // receiver back-pressure, changed only at the falling edge
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // transaction counters and the watchdog on a stuck handshake
  always @(posedge clk) begin
    if (rst) begin
      quiet     <= 0;
      bytes_out <= 0;
      msgs_out  <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        bytes_out <= bytes_out + 1;
        if (msg_last) msgs_out <= msgs_out + 1;
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet <= 0;
      end else if (quiet >= QUIET_LIMIT - 1) begin
        $display("watchdog: no transaction for %0d cycles, %0d bytes still due",
                 QUIET_LIMIT, pending);
        $display("Test completed with failures");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  // one input transaction; the sender may idle first, then holds the byte until taken
  task automatic feed_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_byte  = b;
    do @(posedge clk); while (in_stall);
    bytes_fed++;
  endtask

  // header as three little-endian words, then a random payload
  task automatic feed_message(input logic [31:0] typ, input logic [31:0] tm,
                              input logic [31:0] len);
    logic [95:0] hdr;
    int          k;
    hdr = {len, tm, typ};
    for (k = 0; k < HDR_BYTES; k++) feed_byte(hdr[k*8 +: 8]);
    for (k = 0; k < len; k++) feed_byte(8'($urandom));
  endtask

  // stop sending and wait until every predicted byte has come out
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // registers change only with the block idle: drained, then a rejected
  // message may still be in flight, so give it the hold-off too
  task automatic set_config(input logic [31:0] limit, input logic [31:0] slack_word);
    drain();
    repeat (HOLD_OFF) @(negedge clk);
    write_reg(CFG_TYPE_LIMIT, limit);
    write_reg(CFG_TIME_SLACK, slack_word);
    type_cap  = limit;
    slack_now = slack_word[7:0];
  endtask

  // mostly well-formed messages with good types and times near the newest kept
  // time; the rest bad types with arbitrary times
  task automatic random_message();
    logic [31:0] typ;
    logic [31:0] tm;
    logic [31:0] len;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70 && type_cap != 32'd0) begin
      typ = ($urandom_range(3) == 0) ? type_cap : 32'($urandom_range(type_cap, 1));
      if ($urandom_range(1)) begin
        // newer than anything kept so far: always kept and moves the maximum
        time_now = time_now + 32'($urandom_range(300, 1));
        tm = time_now;
      end else begin
        // lagging, around the slack boundary
        tm = time_now - 32'($urandom_range(slack_now + 3, 0));
      end
    end else begin
      case ($urandom_range(2))
        0: typ = 32'd0;
        1: typ = (type_cap == '1) ? 32'd0 : type_cap + 32'd1;
        default: typ = (type_cap == '1) ? 32'd0 :
                       32'($urandom_range(32'hFFFF_FFFF, type_cap + 1));
      endcase
      tm = $urandom;
    end
    case ($urandom_range(9))
      0, 1: len = 32'd0;
      9: len = 32'($urandom_range(30, 13));
      default: len = 32'($urandom_range(12, 1));
    endcase
    feed_message(typ, tm, len);
  endtask

  // random messages until the byte budget is spent; with every_pause set the
  // sender waits for the output to empty before every so many messages
  task automatic random_phase(input int budget, input int every_pause);
    int goal;
    int n;
    goal = bytes_fed + budget;
    n    = 0;
    while (bytes_fed < goal) begin
      if (every_pause != 0 && n != 0 && n % every_pause == 0) drain();
      random_message();
      n++;
    end
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_byte   = 8'd0;
    cfg_we    = 1'b0;
    cfg_index = CFG_TYPE_LIMIT;
    cfg_data  = 32'd0;
    idle_pct  = 0;
    stall_pct = 0;
    type_cap  = TYPE_LIMIT_RST;
    slack_now = TIME_SLACK_RST;
    time_now  = 32'd0;
    bytes_fed = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed, reset configuration (limit 4, slack 2), no idling
    // time zero at reset is kept through the slack alone; empty payload
    feed_message(32'd1, 32'd0, 32'd0);
    // type at the limit, newer time, short payload
    feed_message(32'd4, 32'd100, 32'd3);
    // type just above the limit with a newer time: rejected, maximum stays
    feed_message(32'd5, 32'd200, 32'd2);
    // type zero: rejected
    feed_message(32'd0, 32'd300, 32'd1);
    // lag equal to the slack is not enough
    feed_message(32'd2, 32'd98, 32'd1);
    // lag inside the slack is kept
    feed_message(32'd3, 32'd99, 32'd1);
    time_now = 32'd100;

    // no idling on either side
    random_phase(PHASE_BYTES, 0);

    // lowest non-zero limit and no slack; sender idles with a 66 percent chance
    set_config(32'd1, 32'd0);
    write_reg(CFG_SPARE_A, 32'hFFFF_FFFF);
    write_reg(CFG_SPARE_B, 32'h0000_0000);
    idle_pct  = 66;
    stall_pct = 0;
    random_phase(PHASE_BYTES, 0);

    // widest limit and slack (upper bits of the slack word must be dropped);
    // receiver stalls with a 66 percent chance, sender pauses for the output to empty
    set_config(32'hFFFF_FFFF, 32'h5A5A_5AFF);
    idle_pct  = 0;
    stall_pct = 66;
    random_phase(PHASE_BYTES, 1);

    // limit zero rejects every type
    set_config(32'd0, 32'd7);
    idle_pct  = 27;
    stall_pct = 27;
    random_phase(15, 0);

    // random middle setting, both sides idling
    set_config(32'($urandom_range(50, 2)), $urandom);
    random_phase(PHASE_BYTES, 0);

    // wrapping time check last, since it leaves the maximum near the top
    set_config(32'hFFFF_FFFF, 32'd255);
    idle_pct  = 0;
    stall_pct = 0;
    feed_message(32'd1, 32'hFFFF_FFF0, 32'd0);
    // time plus slack wraps past zero: rejected
    feed_message(32'd1, 32'hFFFF_FFE0, 32'd1);
    // time plus slack lands just below the wrap: kept
    feed_message(32'd1, 32'hFFFF_FF00, 32'd1);

    drain();
    repeat (2 * HOLD_OFF) @(negedge clk);

    $display("fed %0d bytes through six register settings and four pacing modes;",
             bytes_fed);
    $display("%0d bytes of %0d kept messages came out, %0d mismatches",
             bytes_out, msgs_out, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: timed_message_stream_filter.f
hw/rtl/tmsf_pkg.sv
hw/rtl/tmsf_front.sv
hw/rtl/tmsf_queue.sv
hw/rtl/tmsf_back.sv
hw/rtl/timed_message_stream_filter.sv
verif/tmsf_checker.sv
verif/timed_message_stream_filter_test.sv
